FILE: design/macd_pkg.sv
// shared types, constants and helper functions for the macd indicator
`default_nettype none

package macd_pkg;

    // field and state widths
    localparam int PRICE_W    = 32;
    localparam int TIME_W     = 48;
    localparam int PERIOD_W   = 8;
    localparam int ALPHA_W    = 17;
    localparam int LINE_W     = 33;
    localparam int SIG_W      = 34;
    localparam int HIST_W     = 34;
    localparam int SUM_W      = 41;
    localparam int SIG_SUM_W  = 42;
    localparam int CNT_W      = 10;
    localparam int CFG_IDX_W  = 3;

    // arithmetic constants
    localparam int MAX_PERIOD = 255;
    localparam int CNT_CAP    = 2 * MAX_PERIOD;
    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_ONE  = 1 << FRAC_BITS;

    // shared unit widths
    localparam int EMA_W      = 35;
    localparam int PROD_W     = EMA_W + ALPHA_W + 1;
    localparam int DIV_W      = SIG_SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ALPHA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_ALPHA  = 3'd5;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FAST,
        S_FAST_DIV,
        S_FAST_EMA,
        S_SLOW,
        S_SLOW_DIV,
        S_SLOW_EMA,
        S_LINE,
        S_SIG,
        S_SIG_DIV,
        S_SIG_EMA,
        S_OUT
    } seq_state_t;

    // request to the shared ema step unit
    typedef struct packed {
        logic               valid;
        logic [EMA_W-1:0]   base;
        logic [EMA_W-1:0]   sample;
        logic [ALPHA_W-1:0] alpha;
    } ema_req_t;

    // request to the shared seed divider
    typedef struct packed {
        logic                valid;
        logic [DIV_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    // zero period acts as one, long period saturates
    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        logic [PERIOD_W-1:0] r;
        r = p;
        if (p == '0)
            r = PERIOD_W'(1);
        else if (32'(p) > MAX_PERIOD)
            r = PERIOD_W'(MAX_PERIOD);
        return r;
    endfunction

    // smoothing factor clamped to one
    function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] a);
        logic [ALPHA_W-1:0] r;
        r = a;
        if (32'(a) > ALPHA_ONE)
            r = ALPHA_W'(ALPHA_ONE);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/macd_ema_unit.sv
// shared ema step unit: base + floor((sample - base) * alpha / 2^frac)
`default_nettype none

module macd_ema_unit
    import macd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ema_req_t         req,
    output logic                  done,
    output logic [EMA_W-1:0]      result
);

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     done_reg;
    logic signed [EMA_W-1:0]  diff_reg;
    logic [EMA_W-1:0]         base1_reg;
    logic [EMA_W-1:0]         base2_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_shr;
    logic [EMA_W-1:0]         result_reg;

    // floor division by 2^frac is an arithmetic shift
    assign prod_shr = prod_reg >>> FRAC_BITS;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // difference, product, then accumulate
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            diff_reg  <= $signed(req.sample) - $signed(req.base);
            base1_reg <= req.base;
            alpha_reg <= req.alpha;
        end
        if (v1_reg)
        begin
            prod_reg  <= diff_reg * $signed({1'b0, alpha_reg});
            base2_reg <= base1_reg;
        end
        if (v2_reg)
        begin
            result_reg <= base2_reg + prod_shr[EMA_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: design/macd_div_unit.sv
// shared seed divider: signed sum over small period, truncating toward zero
`default_nettype none

module macd_div_unit
    import macd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire div_req_t      req,
    output logic               done,
    output logic [DIV_W-1:0]   quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PERIOD_W-1:0]   dsr_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic                  neg_reg;
    logic [DIV_W-1:0]      result_reg;
    logic [PERIOD_W:0]     trial;
    logic                  fits;
    logic [PERIOD_W:0]     rem_sub;
    logic [DIV_W-1:0]      magnitude;

    // one restoring step per cycle
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign rem_sub   = trial - {1'b0, dsr_reg};
    assign magnitude = req.dividend[DIV_W-1] ? (~req.dividend + DIV_W'(1)) : req.dividend;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.valid)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg && cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
            else if (busy_reg)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            quo_reg <= magnitude;
            neg_reg <= req.dividend[DIV_W-1];
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            rem_reg <= fits ? rem_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
        else if (busy_reg)
        begin
            result_reg <= neg_reg ? (~quo_reg + DIV_W'(1)) : quo_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = result_reg;

endmodule

`default_nettype wire

FILE: design/macd_indicator.sv
// top level: macd line, signal and histogram over a bar stream
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_ready   | close_price, bar_time, series_start
//  out      | out_valid / out_ready | line_valid, line_value, signal_valid,
//           |                       | signal_value, histogram_value, result_time
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// with all averages running, a bar between input transfers passes an issue state and a
// wait on the shared multiply pipeline for each of three ema steps, plus line, output and idle.
// a seed sum step only adds the bar into its sum; the bar closing a seed window waits
// for that mean from the shared bit-serial divider.
// in_ready is high only while idle; a result still waiting stalls the output step.
// reset restores the register defaults and clears the series; cfg is always ready.
`default_nettype none

module macd_indicator
    import macd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // bar input
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PRICE_W-1:0]    close_price,
    input  wire logic [TIME_W-1:0]     bar_time,
    input  wire logic                  series_start,
    // result output
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       line_valid,
    output logic [LINE_W-1:0]          line_value,
    output logic                       signal_valid,
    output logic [LINE_W-1:0]          signal_value,
    output logic [HIST_W-1:0]          histogram_value,
    output logic [TIME_W-1:0]          result_time,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ALPHA_W-1:0]    cfg_data
);

    seq_state_t state_reg, state_next;

    logic [PERIOD_W-1:0] fast_period_reg, slow_period_reg, signal_period_reg;
    logic [ALPHA_W-1:0]  fast_alpha_reg, slow_alpha_reg, signal_alpha_reg;

    logic [CNT_W-1:0]     bar_count_reg, bar_count_next;
    logic [SUM_W-1:0]     fast_sum_reg, fast_sum_next;
    logic [SUM_W-1:0]     slow_sum_reg, slow_sum_next;
    logic [LINE_W-1:0]    fast_avg_reg, fast_avg_next;
    logic [LINE_W-1:0]    slow_avg_reg, slow_avg_next;
    logic [SIG_SUM_W-1:0] signal_sum_reg, signal_sum_next;
    logic [SIG_W-1:0]     signal_avg_reg, signal_avg_next;
    logic                 lv_reg, lv_next;
    logic                 out_valid_reg, out_valid_next;

    logic [PRICE_W-1:0]   x_reg, x_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [LINE_W-1:0]    m_reg, m_next;
    logic                 line_valid_reg, line_valid_next;
    logic [LINE_W-1:0]    line_value_reg, line_value_next;
    logic                 signal_valid_reg, signal_valid_next;
    logic [LINE_W-1:0]    signal_value_reg, signal_value_next;
    logic [HIST_W-1:0]    hist_reg, hist_next;
    logic [TIME_W-1:0]    result_time_reg, result_time_next;

    logic [PERIOD_W-1:0]  slow_p, fast_raw, fast_p, sig_p, slow_m1;
    logic [CNT_W-1:0]     k;
    logic                 n_lt_f, n_eq_fm1, n_lt_s, n_eq_sm1, line_on;
    logic                 k_lt_g, k_eq_gm1, k_ge_gm1;
    logic [SUM_W-1:0]     x_ext, fast_sum_add, slow_sum_add;
    logic [SIG_SUM_W-1:0] sig_sum_add;
    logic [HIST_W-1:0]    hist_calc;

    ema_req_t            ema_req;
    logic                ema_done;
    logic [EMA_W-1:0]    ema_result;
    div_req_t            div_req;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;

    macd_ema_unit u_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ema_req),
        .done   (ema_done),
        .result (ema_result)
    );

    macd_div_unit u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // effective periods, fast limited to slow
    assign slow_p   = eff_period(slow_period_reg);
    assign fast_raw = eff_period(fast_period_reg);
    assign fast_p   = (fast_raw > slow_p) ? slow_p : fast_raw;
    assign sig_p    = eff_period(signal_period_reg);
    assign slow_m1  = slow_p - PERIOD_W'(1);

    // window position of the current bar
    assign n_lt_f   = bar_count_reg < CNT_W'(fast_p);
    assign n_eq_fm1 = bar_count_reg == CNT_W'(fast_p - PERIOD_W'(1));
    assign n_lt_s   = bar_count_reg < CNT_W'(slow_p);
    assign n_eq_sm1 = bar_count_reg == CNT_W'(slow_m1);
    assign line_on  = bar_count_reg >= CNT_W'(slow_m1);
    assign k        = bar_count_reg - CNT_W'(slow_m1);
    assign k_lt_g   = k < CNT_W'(sig_p);
    assign k_eq_gm1 = k == CNT_W'(sig_p - PERIOD_W'(1));
    assign k_ge_gm1 = k >= CNT_W'(sig_p - PERIOD_W'(1));

    // seed sums and histogram
    assign x_ext        = {{(SUM_W-PRICE_W){1'b0}}, x_reg};
    assign fast_sum_add = fast_sum_reg + x_ext;
    assign slow_sum_add = slow_sum_reg + x_ext;
    assign sig_sum_add  = signal_sum_reg + {{(SIG_SUM_W-LINE_W){m_reg[LINE_W-1]}}, m_reg};
    assign hist_calc    = {{(HIST_W-LINE_W){m_reg[LINE_W-1]}}, m_reg} - signal_avg_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next        = state_reg;
        bar_count_next    = bar_count_reg;
        fast_sum_next     = fast_sum_reg;
        slow_sum_next     = slow_sum_reg;
        fast_avg_next     = fast_avg_reg;
        slow_avg_next     = slow_avg_reg;
        signal_sum_next   = signal_sum_reg;
        signal_avg_next   = signal_avg_reg;
        lv_next           = lv_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        x_next            = x_reg;
        time_next         = time_reg;
        m_next            = m_reg;
        line_valid_next   = line_valid_reg;
        line_value_next   = line_value_reg;
        signal_valid_next = signal_valid_reg;
        signal_value_next = signal_value_reg;
        hist_next         = hist_reg;
        result_time_next  = result_time_reg;
        ema_req           = '0;
        div_req           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = close_price;
                    time_next = bar_time;
                    if (series_start)
                    begin
                        bar_count_next  = '0;
                        fast_sum_next   = '0;
                        slow_sum_next   = '0;
                        fast_avg_next   = '0;
                        slow_avg_next   = '0;
                        signal_sum_next = '0;
                        signal_avg_next = '0;
                    end
                    state_next = S_FAST;
                end
            end
            S_FAST:
            begin
                if (n_lt_f)
                begin
                    fast_sum_next = fast_sum_add;
                    if (n_eq_fm1)
                    begin
                        div_req.valid    = 1'b1;
                        div_req.dividend = {{(DIV_W-SUM_W){fast_sum_add[SUM_W-1]}},
                                            fast_sum_add};
                        div_req.divisor  = fast_p;
                        state_next       = S_FAST_DIV;
                    end
                    else
                    begin
                        state_next = S_SLOW;
                    end
                end
                else
                begin
                    ema_req.valid  = 1'b1;
                    ema_req.base   = {{(EMA_W-LINE_W){fast_avg_reg[LINE_W-1]}}, fast_avg_reg};
                    ema_req.sample = {{(EMA_W-PRICE_W){1'b0}}, x_reg};
                    ema_req.alpha  = sat_alpha(fast_alpha_reg);
                    state_next     = S_FAST_EMA;
                end
            end
            S_FAST_DIV:
            begin
                if (div_done)
                begin
                    fast_avg_next = div_quo[LINE_W-1:0];
                    state_next    = S_SLOW;
                end
            end
            S_FAST_EMA:
            begin
                if (ema_done)
                begin
                    fast_avg_next = ema_result[LINE_W-1:0];
                    state_next    = S_SLOW;
                end
            end
            S_SLOW:
            begin
                if (n_lt_s)
                begin
                    slow_sum_next = slow_sum_add;
                    if (n_eq_sm1)
                    begin
                        div_req.valid    = 1'b1;
                        div_req.dividend = {{(DIV_W-SUM_W){slow_sum_add[SUM_W-1]}},
                                            slow_sum_add};
                        div_req.divisor  = slow_p;
                        state_next       = S_SLOW_DIV;
                    end
                    else
                    begin
                        state_next = S_LINE;
                    end
                end
                else
                begin
                    ema_req.valid  = 1'b1;
                    ema_req.base   = {{(EMA_W-LINE_W){slow_avg_reg[LINE_W-1]}}, slow_avg_reg};
                    ema_req.sample = {{(EMA_W-PRICE_W){1'b0}}, x_reg};
                    ema_req.alpha  = sat_alpha(slow_alpha_reg);
                    state_next     = S_SLOW_EMA;
                end
            end
            S_SLOW_DIV:
            begin
                if (div_done)
                begin
                    slow_avg_next = div_quo[LINE_W-1:0];
                    state_next    = S_LINE;
                end
            end
            S_SLOW_EMA:
            begin
                if (ema_done)
                begin
                    slow_avg_next = ema_result[LINE_W-1:0];
                    state_next    = S_LINE;
                end
            end
            S_LINE:
            begin
                lv_next = line_on;
                if (line_on)
                begin
                    m_next     = fast_avg_reg - slow_avg_reg;
                    state_next = S_SIG;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SIG:
            begin
                if (k_lt_g)
                begin
                    signal_sum_next = sig_sum_add;
                    if (k_eq_gm1)
                    begin
                        div_req.valid    = 1'b1;
                        div_req.dividend = sig_sum_add;
                        div_req.divisor  = sig_p;
                        state_next       = S_SIG_DIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    ema_req.valid  = 1'b1;
                    ema_req.base   = {{(EMA_W-SIG_W){signal_avg_reg[SIG_W-1]}},
                                      signal_avg_reg};
                    ema_req.sample = {{(EMA_W-LINE_W){m_reg[LINE_W-1]}}, m_reg};
                    ema_req.alpha  = sat_alpha(signal_alpha_reg);
                    state_next     = S_SIG_EMA;
                end
            end
            S_SIG_DIV:
            begin
                if (div_done)
                begin
                    signal_avg_next = div_quo[SIG_W-1:0];
                    state_next      = S_OUT;
                end
            end
            S_SIG_EMA:
            begin
                if (ema_done)
                begin
                    signal_avg_next = ema_result[SIG_W-1:0];
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    line_valid_next   = lv_reg;
                    line_value_next   = lv_reg ? m_reg : '0;
                    signal_valid_next = lv_reg && k_ge_gm1;
                    signal_value_next = (lv_reg && k_ge_gm1) ? signal_avg_reg[LINE_W-1:0] : '0;
                    hist_next         = (lv_reg && k_ge_gm1) ? hist_calc : '0;
                    result_time_next  = time_reg;
                    if (bar_count_reg < CNT_W'(CNT_CAP))
                        bar_count_next = bar_count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bar_count_reg  <= '0;
            fast_sum_reg   <= '0;
            slow_sum_reg   <= '0;
            fast_avg_reg   <= '0;
            slow_avg_reg   <= '0;
            signal_sum_reg <= '0;
            signal_avg_reg <= '0;
            lv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bar_count_reg  <= bar_count_next;
            fast_sum_reg   <= fast_sum_next;
            slow_sum_reg   <= slow_sum_next;
            fast_avg_reg   <= fast_avg_next;
            slow_avg_reg   <= slow_avg_next;
            signal_sum_reg <= signal_sum_next;
            signal_avg_reg <= signal_avg_next;
            lv_reg         <= lv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        time_reg         <= time_next;
        m_reg            <= m_next;
        line_valid_reg   <= line_valid_next;
        line_value_reg   <= line_value_next;
        signal_valid_reg <= signal_valid_next;
        signal_value_reg <= signal_value_next;
        hist_reg         <= hist_next;
        result_time_reg  <= result_time_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_period_reg   <= PERIOD_W'(12);
            slow_period_reg   <= PERIOD_W'(26);
            signal_period_reg <= PERIOD_W'(9);
            fast_alpha_reg    <= ALPHA_W'(10082);
            slow_alpha_reg    <= ALPHA_W'(4855);
            signal_alpha_reg  <= ALPHA_W'(13107);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FAST_PERIOD:   fast_period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_SLOW_PERIOD:   slow_period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_SIGNAL_PERIOD: signal_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_FAST_ALPHA:    fast_alpha_reg    <= cfg_data;
                CFG_SLOW_ALPHA:    slow_alpha_reg    <= cfg_data;
                CFG_SIGNAL_ALPHA:  signal_alpha_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_valid      = line_valid_reg;
    assign line_value      = line_value_reg;
    assign signal_valid    = signal_valid_reg;
    assign signal_value    = signal_value_reg;
    assign histogram_value = hist_reg;
    assign result_time     = result_time_reg;

    // checks on sequencing and result consistency
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a bar is in progress");

    a_signal_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_valid || !signal_valid))
        else $error("signal flagged without a macd line");

    a_undefined_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_valid |->
            (line_value == '0 && signal_value == '0 && histogram_value == '0))
        else $error("undefined result fields not zero");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bar_count_reg <= CNT_W'(CNT_CAP))
        else $error("bar count beyond its cap");

    a_ema_issue: assert property (@(posedge clk) disable iff (!rst_n)
        ema_req.valid |-> (state_reg == S_FAST || state_reg == S_SLOW || state_reg == S_SIG))
        else $error("ema step issued outside an update state");

endmodule

`default_nettype wire
